>>> rtl/assert_macros.svh
// Assertion macros shared by the receiver window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define SRRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the block clock and reset.
`define SRRW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/srrw_pkg.sv
// Types and constants of the selective repeat receiver window.
package srrw_pkg;

	localparam int SEQ_IN_W = 16;
	localparam int CNT_W    = 7;
	localparam int NEXT_W   = 6;
	localparam int BUF_W    = 7;
	localparam int NEWC_W   = 16;
	localparam int CFG_W    = 16;
	localparam int MAP_W    = 64;
	localparam int WS_W     = 7;
	localparam int SB_W     = 5;
	localparam int IDX_W    = 2;

	localparam logic [BUF_W-1:0]  BUF_MAX = 7'd127;
	localparam logic [WS_W-1:0]   WS_RST  = 7'd8;
	localparam logic [SB_W-1:0]   SB_RST  = 5'd8;
	localparam logic [BUF_W-1:0]  BS_RST  = 7'd8;
	localparam logic [NEWC_W-1:0] MP_RST  = 16'hFFFF;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_WIN_SLOTS    = 2'd0,
		REG_SEQ_BITS     = 2'd1,
		REG_BUFFER_SLOTS = 2'd2,
		REG_PKT_LIMIT    = 2'd3
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	// Admission decision for one packet.
	typedef struct packed {
		logic             take;
		logic             in_order;
		logic             is_new;
		logic [CNT_W-1:0] slot;
	} admit_t;

	// One step of the in-order delivery walk.
	typedef struct packed {
		logic             advance;
		logic [CNT_W-1:0] j;
		logic [CNT_W-1:0] run;
		logic [BUF_W-1:0] bufs;
	} walk_t;

endpackage

>>> rtl/srrw_pkt_if.sv
// Packet request channel: sequence number and lost flag.
interface srrw_pkt_if;
	logic                          valid;
	logic                          ready;
	logic [srrw_pkg::SEQ_IN_W-1:0] seq_num;
	logic                          lost;

	modport source (output valid, output seq_num, output lost, input ready);
	modport sink (input valid, input seq_num, input lost, output ready);
endinterface

>>> rtl/srrw_res_if.sv
// Result request channel: ack bitmap and delivery status.
interface srrw_res_if;
	logic                       valid;
	logic                       ready;
	logic                       ack_sent;
	logic [srrw_pkg::MAP_W-1:0] ack_bitmap;
	logic [srrw_pkg::CNT_W-1:0] delivered_run;
	logic                       window_slid;
	logic                       done_res;

	modport source (output valid, output ack_sent, output ack_bitmap, output delivered_run,
		output window_slid, output done_res, input ready);
	modport sink (input valid, input ack_sent, input ack_bitmap, input delivered_run,
		input window_slid, input done_res, output ready);
endinterface

>>> rtl/srrw_admit.sv
// Window test and admission decision for one arriving packet.
module srrw_admit #(
	parameter int WINDOW_MAX = 64,
	parameter int SEQ_W      = 16
) (
	input  logic [SEQ_W-1:0]                 seq,
	input  logic                             lost,
	input  logic                             stopped,
	input  logic [SEQ_W-1:0]                 base,
	input  logic [SEQ_W-1:0]                 mask,
	input  logic [srrw_pkg::WS_W-1:0]        w,
	input  logic [srrw_pkg::NEXT_W-1:0]      next_slot,
	input  logic [srrw_pkg::BUF_W-1:0]       bufs,
	input  logic [WINDOW_MAX-1:0]            ack,
	output srrw_pkg::admit_t                 adm,
	output logic [WINDOW_MAX-1:0]            onehot
);

	logic [SEQ_W:0]   top_sum;
	logic [SEQ_W-1:0] top;
	logic [SEQ_W-1:0] w_ext;
	logic [SEQ_W-1:0] w_m1;
	logic [SEQ_W-1:0] slot;
	logic             in_range;
	logic             in_window;
	logic             in_order;

	// Top of the window, wrapped into the sequence space.
	assign top_sum = {1'b0, base} + (SEQ_W+1)'(w) - (SEQ_W+1)'(1);
	assign top     = top_sum[SEQ_W-1:0] & mask;
	assign w_ext   = SEQ_W'(w);
	assign w_m1    = w_ext - SEQ_W'(1);

	// Inside test, including the case where the window wraps past zero.
	assign in_range = (seq >= base && seq <= top) ||
		(top < w_m1 && (seq <= top || seq >= base));

	// Slot within the window and its one-hot bit.
	assign slot      = (seq - base) & mask;
	assign in_window = slot < w_ext;
	assign in_order  = slot == SEQ_W'(next_slot);
	assign onehot    = WINDOW_MAX'(1) << slot;

	always_comb begin
		adm.take     = !lost && !stopped && in_range && in_window &&
			(in_order || bufs > srrw_pkg::BUF_W'(1));
		adm.in_order = in_order;
		adm.is_new   = ~|(ack & onehot);
		adm.slot     = slot[srrw_pkg::CNT_W-1:0];
	end

endmodule

>>> rtl/srrw_walk.sv
// Delivery walk step: tests one window slot and advances the run.
module srrw_walk #(
	parameter int WINDOW_MAX = 64
) (
	input  logic [srrw_pkg::CNT_W-1:0] j,
	input  logic [srrw_pkg::CNT_W-1:0] run,
	input  logic [srrw_pkg::BUF_W-1:0] bufs,
	input  logic [srrw_pkg::WS_W-1:0]  w,
	input  logic [WINDOW_MAX-1:0]      ack,
	input  logic [WINDOW_MAX-1:0]      hot,
	output srrw_pkg::walk_t            step
);

	// The slot under test is received and still inside the window.
	always_comb begin
		step.advance = (j < w) && (|(ack & hot));
		step.j       = j + srrw_pkg::CNT_W'(1);
		step.run     = run + srrw_pkg::CNT_W'(1);
		step.bufs    = (bufs < srrw_pkg::BUF_MAX) ? bufs + srrw_pkg::BUF_W'(1) : bufs;
	end

endmodule

>>> rtl/selective_repeat_receiver_window_top.sv
// Selective repeat receiver window: top level with sequencer and result register.
//
// Each accepted packet is answered by exactly one result. An item passes through accept,
// admission and finish when it is not taken into the next in-order slot, and through
// the delivery walk over the delivered run between admission and finish when it is.
// The delivery walk tests one slot bit per cycle in a shared step unit. The finish
// cycle repeats while an earlier result still waits for its taker. The packet channel
// is ready only while the sequencer is idle; the result register lets a finished
// result wait for its taker while the next packet is being accepted. Configuration
// is written through wr_en/wr_index/wr_data and must only change while the block is idle.
`include "assert_macros.svh"

module selective_repeat_receiver_window_top #(
	parameter int WINDOW_MAX   = 64,
	parameter int SEQ_BITS_MAX = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [srrw_pkg::IDX_W-1:0]   wr_index,
	input  logic [srrw_pkg::CFG_W-1:0]   wr_data,
	srrw_pkt_if.sink                     pkt,
	srrw_res_if.source                   res
);

	localparam int SEQ_W = (SEQ_BITS_MAX > srrw_pkg::SEQ_IN_W) ? SEQ_BITS_MAX
		: srrw_pkg::SEQ_IN_W;

	srrw_pkg::state_t state_q;

	// Configuration registers.
	logic [srrw_pkg::WS_W-1:0]   ws_q;
	logic [srrw_pkg::SB_W-1:0]   sb_q;
	logic [srrw_pkg::BUF_W-1:0]  bs_q;
	logic [srrw_pkg::NEWC_W-1:0] mp_q;

	// Receiver state.
	logic [WINDOW_MAX-1:0]       ack_q;
	logic [SEQ_W-1:0]            base_q;
	logic [srrw_pkg::NEXT_W-1:0] next_q;
	logic [srrw_pkg::BUF_W-1:0]  bufs_q;
	logic [srrw_pkg::NEWC_W-1:0] newc_q;

	// Packet being worked on.
	logic [srrw_pkg::SEQ_IN_W-1:0] seq_q;
	logic                          lost_q;
	logic                          taken_q;
	logic [srrw_pkg::CNT_W-1:0]    j_q;
	logic [srrw_pkg::CNT_W-1:0]    run_q;
	logic [WINDOW_MAX-1:0]         hot_q;

	// Result register.
	logic                        res_valid_q;
	logic                        res_sent_q;
	logic [srrw_pkg::MAP_W-1:0]  res_bitmap_q;
	logic [srrw_pkg::CNT_W-1:0]  res_run_q;
	logic                        res_slid_q;
	logic                        res_done_q;

	logic [srrw_pkg::WS_W-1:0] w_eff;
	logic [5:0]                sb_eff;
	logic [SEQ_W:0]            mask_wide;
	logic [SEQ_W-1:0]          mask;
	logic [WINDOW_MAX-1:0]     full_vec;
	logic                      all_acked;
	logic                      stopped;
	logic                      fin_load;
	logic [WINDOW_MAX-1:0]     onehot;
	srrw_pkg::admit_t          adm;
	srrw_pkg::walk_t           step;

	// Effective window size and sequence mask.
	always_comb begin
		if (ws_q == '0) begin
			w_eff = srrw_pkg::WS_W'(1);
		end else if (ws_q > srrw_pkg::WS_W'(WINDOW_MAX)) begin
			w_eff = srrw_pkg::WS_W'(WINDOW_MAX);
		end else begin
			w_eff = ws_q;
		end
		sb_eff = ({1'b0, sb_q} > 6'(SEQ_BITS_MAX)) ? 6'(SEQ_BITS_MAX) : {1'b0, sb_q};
	end

	assign mask_wide = ((SEQ_W+1)'(1) << sb_eff) - (SEQ_W+1)'(1);
	assign mask      = mask_wide[SEQ_W-1:0];

	// Full-window check over the low window bits.
	assign full_vec  = ~({WINDOW_MAX{1'b1}} << w_eff);
	assign all_acked = (ack_q & full_vec) == full_vec;
	assign stopped   = newc_q >= mp_q;
	assign fin_load  = (state_q == srrw_pkg::ST_FINISH) && (!res_valid_q || res.ready);

	srrw_admit #(
		.WINDOW_MAX (WINDOW_MAX),
		.SEQ_W      (SEQ_W)
	) u_admit (
		.seq       (SEQ_W'(seq_q)),
		.lost      (lost_q),
		.stopped   (stopped),
		.base      (base_q),
		.mask      (mask),
		.w         (w_eff),
		.next_slot (next_q),
		.bufs      (bufs_q),
		.ack       (ack_q),
		.adm       (adm),
		.onehot    (onehot)
	);

	srrw_walk #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_walk (
		.j    (j_q),
		.run  (run_q),
		.bufs (bufs_q),
		.w    (w_eff),
		.ack  (ack_q),
		.hot  (hot_q),
		.step (step)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= srrw_pkg::WS_RST;
			sb_q <= srrw_pkg::SB_RST;
			bs_q <= srrw_pkg::BS_RST;
			mp_q <= srrw_pkg::MP_RST;
		end else if (wr_en) begin
			case (srrw_pkg::cfg_reg_t'(wr_index))
				srrw_pkg::REG_WIN_SLOTS: begin
					ws_q <= wr_data[srrw_pkg::WS_W-1:0];
				end
				srrw_pkg::REG_SEQ_BITS: begin
					sb_q <= wr_data[srrw_pkg::SB_W-1:0];
				end
				srrw_pkg::REG_BUFFER_SLOTS: begin
					bs_q <= wr_data[srrw_pkg::BUF_W-1:0];
				end
				srrw_pkg::REG_PKT_LIMIT: begin
					mp_q <= wr_data[srrw_pkg::NEWC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer and receiver state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srrw_pkg::ST_IDLE;
			ack_q   <= '0;
			base_q  <= '0;
			next_q  <= '0;
			bufs_q  <= srrw_pkg::BS_RST;
			newc_q  <= '0;
			taken_q <= 1'b0;
			j_q     <= '0;
			run_q   <= '0;
			hot_q   <= '0;
			seq_q   <= '0;
			lost_q  <= 1'b0;
		end else begin
			case (state_q)
				srrw_pkg::ST_IDLE: begin
					if (pkt.valid) begin
						seq_q   <= pkt.seq_num;
						lost_q  <= pkt.lost;
						state_q <= srrw_pkg::ST_EVAL;
					end
				end
				srrw_pkg::ST_EVAL: begin
					taken_q <= adm.take;
					run_q   <= '0;
					state_q <= srrw_pkg::ST_FINISH;
					if (adm.take) begin
						ack_q <= ack_q | onehot;
						if (adm.is_new) begin
							newc_q <= newc_q + srrw_pkg::NEWC_W'(1);
						end
						if (bufs_q != '0) begin
							bufs_q <= bufs_q - srrw_pkg::BUF_W'(1);
						end
						if (adm.in_order) begin
							j_q     <= adm.slot;
							hot_q   <= onehot;
							state_q <= srrw_pkg::ST_WALK;
						end
					end
				end
				srrw_pkg::ST_WALK: begin
					if (step.advance) begin
						j_q    <= step.j;
						run_q  <= step.run;
						bufs_q <= step.bufs;
						hot_q  <= hot_q << 1;
					end else begin
						// Next in-order slot wraps to zero at the window end.
						next_q  <= (j_q == w_eff) ? '0 : j_q[srrw_pkg::NEXT_W-1:0];
						state_q <= srrw_pkg::ST_FINISH;
					end
				end
				srrw_pkg::ST_FINISH: begin
					if (fin_load) begin
						if (taken_q && all_acked) begin
							ack_q  <= '0;
							base_q <= (base_q + SEQ_W'(w_eff)) & mask;
							bufs_q <= bs_q;
						end
						state_q <= srrw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= srrw_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload, captured before any slide.
	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_sent_q   <= taken_q;
			res_bitmap_q <= taken_q ? srrw_pkg::MAP_W'(ack_q) : '0;
			res_run_q    <= run_q;
			res_slid_q   <= taken_q && all_acked;
			res_done_q   <= stopped;
		end
	end

	assign pkt.ready         = state_q == srrw_pkg::ST_IDLE;
	assign res.valid         = res_valid_q;
	assign res.ack_sent      = res_sent_q;
	assign res.ack_bitmap    = res_bitmap_q;
	assign res.delivered_run = res_run_q;
	assign res.window_slid   = res_slid_q;
	assign res.done_res      = res_done_q;

	// The walk never runs past the window end.
	`SRRW_ASSERT_IMP(a_walk_bound, clk, arst_n, state_q == srrw_pkg::ST_WALK,
		j_q <= w_eff, "walk index beyond window")
	// A slide only comes with a taken packet.
	`SRRW_ASSERT_IMP(a_slid_taken, clk, arst_n, res_valid_q && res_slid_q,
		res_sent_q, "slide without taken packet")
	// An ignored packet reports nothing but the done flag.
	`SRRW_ASSERT_IMP(a_ignored_zero, clk, arst_n, res_valid_q && !res_sent_q,
		res_bitmap_q == '0 && res_run_q == '0, "ignored packet has payload")
	// A full window is cleared once its result is loaded.
	`SRRW_ASSERT_NXT(a_slide_clears, clk, arst_n, fin_load && taken_q && all_acked,
		ack_q == '0, "ack bits not cleared on slide")

endmodule
